@@ hdl/fvst_pkg.sv @@
// shared types and constants for the four-voice square tone scheduler
// no dependencies
package fvst_pkg;

  // fixed field widths of the transactions and configuration registers
  localparam int PERIOD_WIDTH    = 16;
  localparam int INTERVAL_WIDTH  = 16;
  localparam int LEVELS_WIDTH    = 4;
  localparam int CFG_INDEX_WIDTH = 2;

  localparam logic [PERIOD_WIDTH-1:0] PERIOD_RESET = 16'd1024;

  typedef logic [PERIOD_WIDTH-1:0] period_t;

endpackage

@@ hdl/fvst_step.sv @@
// one scheduler step: toggle and reload expired voices, find the new minimum, subtract it
// depends on fvst_pkg
module fvst_step
  import fvst_pkg::*;
#(
  parameter int VOICE_COUNT = 4,
  parameter int COUNT_WIDTH = 16
) (
  input  logic [VOICE_COUNT-1:0][COUNT_WIDTH-1:0] counts,
  input  period_t [VOICE_COUNT-1:0]               periods,
  input  logic [VOICE_COUNT-1:0]                  levels,
  output logic [VOICE_COUNT-1:0][COUNT_WIDTH-1:0] counts_nxt,
  output logic [VOICE_COUNT-1:0]                  levels_nxt,
  output logic [COUNT_WIDTH-1:0]                  interval
);

  logic [VOICE_COUNT-1:0][COUNT_WIDTH-1:0] loaded;
  logic [VOICE_COUNT-1:0]                  expired;
  logic [COUNT_WIDTH-1:0]                  low;

  // a voice at zero flips and reloads; with no voice at zero nothing reloads
  always_comb begin
    for (int i = 0; i < VOICE_COUNT; i++) begin
      expired[i]    = (counts[i] == '0);
      loaded[i]     = expired[i] ? COUNT_WIDTH'(periods[i]) : counts[i];
      levels_nxt[i] = levels[i] ^ expired[i];
    end
  end

  // minimum over all VOICE_COUNT voices
  always_comb begin
    low = loaded[0];
    for (int i = 1; i < VOICE_COUNT; i++) begin
      if (loaded[i] < low) begin
        low = loaded[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < VOICE_COUNT; i++) begin
      counts_nxt[i] = loaded[i] - low;
    end
  end

  assign interval = low;

endmodule

@@ hdl/four_voice_square_tone_scheduler.sv @@
// four-voice square tone scheduler: inputs are registered in the input stage, results in
// the result register; one transaction per cycle unless out_stall holds a pending result,
// since the whole step (reload, 4-way minimum, subtract) sits between the two registers.
// synchronous active-low reset: counts and levels zero, periods 1024, both stages empty.
// input transactions with expiry low are consumed without a result and leave state alone.
module four_voice_square_tone_scheduler
  import fvst_pkg::*;
#(
  parameter int VOICE_COUNT = 4,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // configuration write port
  input  logic                       cfg_wr_en,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [PERIOD_WIDTH-1:0]    cfg_wdata,
  // expiry events
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_expiry,
  // results
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [LEVELS_WIDTH-1:0]    out_wave_levels,
  output logic [INTERVAL_WIDTH-1:0]  out_next_interval
);

  // period registers, one per active voice
  period_t [VOICE_COUNT-1:0] period_r;

  // scheduler state
  logic [VOICE_COUNT-1:0][COUNT_WIDTH-1:0] counts_r;
  logic [VOICE_COUNT-1:0][COUNT_WIDTH-1:0] counts_nxt;
  logic [VOICE_COUNT-1:0]                  levels_r;
  logic [VOICE_COUNT-1:0]                  levels_nxt;
  logic [COUNT_WIDTH-1:0]                  interval;

  // input stage
  logic s1_valid_r;
  logic s1_valid_nxt;
  logic s1_expiry_r;

  // result register
  logic                      out_valid_r;
  logic                      out_valid_nxt;
  logic [LEVELS_WIDTH-1:0]   out_levels_r;
  logic [INTERVAL_WIDTH-1:0] out_interval_r;

  // handshake control
  logic in_accept;
  logic out_load;
  logic s1_fire;
  logic step;
  logic cnt_any_zero;

  // the result register may take a new value when empty or being drained this cycle
  assign out_load  = !out_valid_r || !out_stall;
  // an expiry needs a free result slot; a non-event leaves at once
  assign s1_fire   = s1_valid_r && (!s1_expiry_r || out_load);
  assign step      = s1_valid_r && s1_expiry_r && out_load;
  assign in_stall  = s1_valid_r && !s1_fire;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  fvst_step #(
    .VOICE_COUNT(VOICE_COUNT),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_step (
    .counts    (counts_r),
    .periods   (period_r),
    .levels    (levels_r),
    .counts_nxt(counts_nxt),
    .levels_nxt(levels_nxt),
    .interval  (interval)
  );

  // control state, scheduler state and period registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      counts_r    <= '0;
      levels_r    <= '0;
      for (int i = 0; i < VOICE_COUNT; i++) begin
        period_r[i] <= PERIOD_RESET;
      end
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (step) begin
        counts_r <= counts_nxt;
        levels_r <= levels_nxt;
      end
      // writes to indexes without a voice fall through
      for (int i = 0; i < VOICE_COUNT; i++) begin
        if (cfg_wr_en && cfg_index == CFG_INDEX_WIDTH'(i)) begin
          period_r[i] <= cfg_wdata;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_expiry_r <= in_expiry;
    end
    if (step) begin
      out_levels_r   <= LEVELS_WIDTH'(levels_nxt);
      out_interval_r <= INTERVAL_WIDTH'(interval);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_wave_levels   = out_levels_r;
  assign out_next_interval = out_interval_r;

  // after a step the minimum has been subtracted, so some voice sits at zero
  always_comb begin
    cnt_any_zero = 1'b0;
    for (int i = 0; i < VOICE_COUNT; i++) begin
      if (counts_r[i] == '0) begin
        cnt_any_zero = 1'b1;
      end
    end
  end

  a_zero_after_step: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> cnt_any_zero)
    else $error("no voice count at zero after a step");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !step)
    else $error("step would overwrite a pending result");

  a_levels_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(levels_r))
    else $error("voice levels changed without an expiry");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_valid_r)
    else $error("expiry step produced no result");

endmodule
